FILE: rtl/tpsc_pkg.sv
// ============================================================================
// tpsc_pkg: shared types and constants of the two-point sensor calibration
// Widths of every pipeline stage follow from the field widths, the channel
// scales and the calibration divisors, so they stay consistent everywhere.
// ============================================================================
package tpsc_pkg;

    // Field widths.
    localparam int X_W       = 16;  // raw count
    localparam int Y_W       = 10;  // calibration value, humidity zero-extended
    localparam int HUMID_Y_W = 8;   // humidity calibration value as written
    localparam int OUT_W     = 32;  // scaled result

    // Channels: 0 is temperature, 1 is humidity.
    localparam int N_CH   = 2;
    localparam int CH_TEMP  = 0;
    localparam int CH_HUMID = 1;

    // Output scales and calibration unit divisors.
    localparam int TEMP_SCALE  = 100;
    localparam int HUMID_SCALE = 100;
    localparam int TEMP_DIV_K  = 8;
    localparam int HUMID_DIV_K = 2;

    localparam int TEMP_K_SHIFT  = $clog2(TEMP_DIV_K);
    localparam int HUMID_K_SHIFT = $clog2(HUMID_DIV_K);
    localparam int MAX_K_SHIFT   = (TEMP_K_SHIFT > HUMID_K_SHIFT) ?
                                   TEMP_K_SHIFT : HUMID_K_SHIFT;
    localparam int MAX_SCALE     = (TEMP_SCALE > HUMID_SCALE) ? TEMP_SCALE : HUMID_SCALE;
    localparam int SCALE_W       = $clog2(MAX_SCALE + 1);

    localparam int CH_SCALE   [N_CH] = '{TEMP_SCALE, HUMID_SCALE};
    localparam int CH_K_SHIFT [N_CH] = '{TEMP_K_SHIFT, HUMID_K_SHIFT};

    // Datapath widths.
    localparam int DX_W  = X_W + 1;            // x - x0 and x1 - x0
    localparam int DY_W  = Y_W + 1;            // y1 - y0
    localparam int P_W   = DX_W + DY_W;        // products y0*d and dy*dx
    localparam int SUM_W = P_W + 1;            // y0*d + dy*dx
    localparam int NUM_W = SUM_W + SCALE_W;    // scaled numerator
    localparam int DEN_W = DX_W + MAX_K_SHIFT; // d*k, signed
    localparam int DM_W  = DEN_W - 1;          // magnitude of d*k
    localparam int QW    = NUM_W - 1;          // magnitude of the numerator

    // Divider: DIV_STEP quotient bits per stage.
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int ACC_W      = DIV_STAGES * DIV_STEP;

    // Register stages from the accepting edge to the result register.
    localparam int PREP_STAGES = 4;
    localparam int LATENCY     = PREP_STAGES + DIV_STAGES + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_X0  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_X1  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_Y0  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_Y1  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_X0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_X1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_Y0 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_Y1 = 4'd7;

    typedef logic signed [X_W-1:0]   t_raw;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic signed [DEN_W-1:0] t_den;
    typedef logic signed [OUT_W-1:0] t_out;

    // One channel's calibration pair.
    typedef struct packed {
        logic signed [X_W-1:0] x0;
        logic signed [X_W-1:0] x1;
        logic [Y_W-1:0]        y0;
        logic [Y_W-1:0]        y1;
    } t_cal;

    // Per-item control that travels with a channel's data.
    typedef struct packed {
        logic vld;
        logic bad;  // zero calibration span
    } t_ctl;

endpackage

FILE: rtl/two_point_sensor_calibration.sv
// ============================================================================
// two_point_sensor_calibration: two-point linear calibration, two channels
// Pipeline: 15 register stages (4 preparation stages, 11 divider stages
// including operand and result registers). Throughput: one item per cycle
// whenever o_busy is low; the receiver cannot stall, so the pipeline never
// holds. Reset is synchronous and active low; it restores the calibration
// registers and empties the pipeline, and o_busy is high for the cycle after
// reset.
// ============================================================================
//
// Each channel maps a raw count x to
//     (y0*d + (y1 - y0)*(x - x0)) * SCALE / (d*k),  d = x1 - x0,
// with k = 8 for temperature (eighths of a degree) and k = 2 for humidity
// (halves of a percent). The quotient truncates toward zero and saturates to
// signed 32 bits. A zero span d raises the channel's invalid flag and forces
// its result to zero.
//
// The preparation pipeline forms the differences, the two products, their
// sum and the scaled numerator. The divider then strips the signs, runs a
// restoring division four quotient bits per stage, and restores the sign and
// saturates in its final register. Both channels run side by side in
// lockstep, so the temperature channel's valid marks the whole result item.
//
// Calibration registers are written through the configuration port, which is
// always ready once out of reset. Writes are expected only while no item is
// in flight; an index past the last register is ignored.
module two_point_sensor_calibration (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item input
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [tpsc_pkg::X_W-1:0]     i_raw_temperature,
    input  logic signed [tpsc_pkg::X_W-1:0]     i_raw_humidity,
    // Result output
    output logic                                o_valid,
    output logic signed [tpsc_pkg::OUT_W-1:0]   o_temperature_scaled,
    output logic signed [tpsc_pkg::OUT_W-1:0]   o_humidity_scaled,
    output logic                                o_temp_span_invalid,
    output logic                                o_humid_span_invalid,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpsc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tpsc_pkg::*;

    // Registered; goes high in the cycle after reset is released; gates both input sides.
    logic r_run;

    // Calibration pairs, one per channel.
    t_cal [N_CH-1:0] r_cal;

    logic            w_accept;
    logic            w_cfg_we;
    t_raw [N_CH-1:0] w_x;
    t_num [N_CH-1:0] w_num;
    t_den [N_CH-1:0] w_den;
    t_ctl [N_CH-1:0] w_prep_ctl;
    t_out [N_CH-1:0] w_res;
    t_ctl [N_CH-1:0] w_out_ctl;

    assign o_busy      = ~r_run;
    assign o_cfg_ready = r_run;
    assign w_accept    = i_start & ~o_busy;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    assign w_x[CH_TEMP]  = i_raw_temperature;
    assign w_x[CH_HUMID] = i_raw_humidity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // Register file. Only the low bits of the data, as wide as the register,
    // are kept; humidity calibration values are zero-extended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal[CH_TEMP].x0  <= '0;
            r_cal[CH_TEMP].x1  <= X_W'(1);
            r_cal[CH_TEMP].y0  <= '0;
            r_cal[CH_TEMP].y1  <= '0;
            r_cal[CH_HUMID].x0 <= '0;
            r_cal[CH_HUMID].x1 <= X_W'(1);
            r_cal[CH_HUMID].y0 <= '0;
            r_cal[CH_HUMID].y1 <= '0;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_X0:  r_cal[CH_TEMP].x0  <= i_cfg_data[X_W-1:0];
                CFG_TEMP_X1:  r_cal[CH_TEMP].x1  <= i_cfg_data[X_W-1:0];
                CFG_TEMP_Y0:  r_cal[CH_TEMP].y0  <= i_cfg_data[Y_W-1:0];
                CFG_TEMP_Y1:  r_cal[CH_TEMP].y1  <= i_cfg_data[Y_W-1:0];
                CFG_HUMID_X0: r_cal[CH_HUMID].x0 <= i_cfg_data[X_W-1:0];
                CFG_HUMID_X1: r_cal[CH_HUMID].x1 <= i_cfg_data[X_W-1:0];
                CFG_HUMID_Y0: r_cal[CH_HUMID].y0 <= Y_W'(i_cfg_data[HUMID_Y_W-1:0]);
                CFG_HUMID_Y1: r_cal[CH_HUMID].y1 <= Y_W'(i_cfg_data[HUMID_Y_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    tpsc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_x     (w_x),
        .i_cal   (r_cal),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_ctl   (w_prep_ctl)
    );

    for (genvar c = 0; c < N_CH; c++) begin : g_div
        tpsc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_num   (w_num[c]),
            .i_den   (w_den[c]),
            .i_ctl   (w_prep_ctl[c]),
            .o_res   (w_res[c]),
            .o_ctl   (w_out_ctl[c])
        );
    end

    assign o_valid              = w_out_ctl[CH_TEMP].vld;
    assign o_temperature_scaled = w_res[CH_TEMP];
    assign o_humidity_scaled    = w_res[CH_HUMID];
    assign o_temp_span_invalid  = w_out_ctl[CH_TEMP].bad;
    assign o_humid_span_invalid = w_out_ctl[CH_HUMID].bad;

`ifndef NO_ASSERTIONS
    // The two channel pipelines must stay in lockstep.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_ctl[CH_TEMP].vld == w_out_ctl[CH_HUMID].vld)
        else $error("channel pipelines out of step");

    // Every result comes from an accepted item.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without a matching item");

    // A zero temperature span forces a zero result.
    a_temp_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_temp_span_invalid) |-> (o_temperature_scaled == '0))
        else $error("temperature flagged invalid with nonzero result");

    // A zero humidity span forces a zero result.
    a_humid_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_humid_span_invalid) |-> (o_humidity_scaled == '0))
        else $error("humidity flagged invalid with nonzero result");
`endif

endmodule

FILE: rtl/tpsc_prep.sv
// ============================================================================
// tpsc_prep: numerator and divisor pipeline
// Four register stages per channel: differences, products, sum, then the
// scale multiply together with the divisor d*k and the zero-span flag.
// ============================================================================
module tpsc_prep (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  tpsc_pkg::t_raw [tpsc_pkg::N_CH-1:0]   i_x,
    input  tpsc_pkg::t_cal [tpsc_pkg::N_CH-1:0]   i_cal,
    output tpsc_pkg::t_num [tpsc_pkg::N_CH-1:0]   o_num,
    output tpsc_pkg::t_den [tpsc_pkg::N_CH-1:0]   o_den,
    output tpsc_pkg::t_ctl [tpsc_pkg::N_CH-1:0]   o_ctl
);
    import tpsc_pkg::*;

    logic [PREP_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PREP_STAGES-2:0], i_vld};
        end
    end

    for (genvar c = 0; c < N_CH; c++) begin : g_lane
        localparam logic signed [SCALE_W:0] L_SCALE = (SCALE_W + 1)'(CH_SCALE[c]);
        localparam int L_SHIFT = CH_K_SHIFT[c];

        logic signed [DX_W-1:0]  r_dx;
        logic signed [DX_W-1:0]  r_d1;
        logic signed [DX_W-1:0]  r_d2;
        logic signed [DX_W-1:0]  r_d3;
        logic signed [DY_W-1:0]  r_dy;
        logic [Y_W-1:0]          r_y0;
        logic signed [P_W-1:0]   r_p1;
        logic signed [P_W-1:0]   r_p2;
        logic signed [SUM_W-1:0] r_sum;
        t_num                    r_num;
        t_den                    r_den;
        logic                    r_bad;

        logic signed [DX_W-1:0]  n_dx;
        logic signed [DX_W-1:0]  n_d;
        logic signed [DY_W-1:0]  n_dy;
        logic signed [P_W-1:0]   n_p1;
        logic signed [P_W-1:0]   n_p2;
        logic signed [SUM_W-1:0] n_sum;
        t_num                    n_num;
        t_den                    n_den;

        always_comb begin
            n_dx  = DX_W'($signed(i_x[c])) - DX_W'($signed(i_cal[c].x0));
            n_d   = DX_W'($signed(i_cal[c].x1)) - DX_W'($signed(i_cal[c].x0));
            n_dy  = DY_W'($signed({1'b0, i_cal[c].y1})) - DY_W'($signed({1'b0, i_cal[c].y0}));
            n_p1  = P_W'($signed({1'b0, r_y0})) * P_W'(r_d1);
            n_p2  = P_W'(r_dy) * P_W'(r_dx);
            n_sum = SUM_W'(r_p1) + SUM_W'(r_p2);
            n_num = NUM_W'(r_sum) * NUM_W'(L_SCALE);
            n_den = DEN_W'(r_d3) <<< L_SHIFT;
        end

        always_ff @(posedge i_clk) begin
            r_dx  <= n_dx;
            r_d1  <= n_d;
            r_dy  <= n_dy;
            r_y0  <= i_cal[c].y0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_d2  <= r_d1;
            r_sum <= n_sum;
            r_d3  <= r_d2;
            r_num <= n_num;
            r_den <= n_den;
            r_bad <= (r_d3 == '0);
        end

        assign o_num[c]     = r_num;
        assign o_den[c]     = r_den;
        assign o_ctl[c].vld = r_vld[PREP_STAGES-1];
        assign o_ctl[c].bad = r_bad;
    end

endmodule

FILE: rtl/tpsc_div.sv
// ============================================================================
// tpsc_div: pipelined signed divider with saturation
// Divides magnitudes with restoring steps, DIV_STEP quotient bits per stage,
// then applies the sign, truncating toward zero, and saturates to 32 bits.
// ============================================================================
module tpsc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpsc_pkg::t_num i_num,
    input  tpsc_pkg::t_den i_den,
    input  tpsc_pkg::t_ctl i_ctl,
    output tpsc_pkg::t_out o_res,
    output tpsc_pkg::t_ctl o_ctl
);
    import tpsc_pkg::*;

    localparam logic [ACC_W-1:0] Q_MAX_POS = ACC_W'({(OUT_W - 1){1'b1}});
    localparam logic [ACC_W-1:0] Q_MAX_NEG = ACC_W'({1'b1, {(OUT_W - 1){1'b0}}});
    localparam t_out RES_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam t_out RES_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // Stage 0 holds the conditioned operands; stage s+1 follows stage s.
    logic [ACC_W-1:0] r_acc [0:DIV_STAGES];
    logic [DM_W-1:0]  r_rem [0:DIV_STAGES];
    logic [DM_W-1:0]  r_dm  [0:DIV_STAGES];
    logic             r_neg [0:DIV_STAGES];
    logic             r_bad [0:DIV_STAGES];
    logic [DIV_STAGES:0] r_vld;

    logic [ACC_W-1:0] n_acc [0:DIV_STAGES-1];
    logic [DM_W-1:0]  n_rem [0:DIV_STAGES-1];

    logic [NUM_W-1:0] w_nabs;
    logic [DEN_W-1:0] w_dabs;

    t_out r_res;
    logic r_out_vld;
    logic r_out_bad;
    t_out n_res;

    assign w_nabs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_dabs = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // Each stage shifts the dividend out of the top of the accumulator and
    // the quotient bits into its bottom.
    always_comb begin
        logic [DM_W:0]    v_trial;
        logic [DM_W-1:0]  v_rem;
        logic [ACC_W-1:0] v_acc;
        for (int s = 0; s < DIV_STAGES; s++) begin
            v_rem = r_rem[s];
            v_acc = r_acc[s];
            for (int j = 0; j < DIV_STEP; j++) begin
                v_trial = {v_rem, v_acc[ACC_W-1]};
                v_acc   = {v_acc[ACC_W-2:0], 1'b0};
                if (v_trial >= (DM_W + 1)'(r_dm[s])) begin
                    v_rem    = DM_W'(v_trial - (DM_W + 1)'(r_dm[s]));
                    v_acc[0] = 1'b1;
                end else begin
                    v_rem = v_trial[DM_W-1:0];
                end
            end
            n_rem[s] = v_rem;
            n_acc[s] = v_acc;
        end
    end

    always_comb begin
        if (r_bad[DIV_STAGES]) begin
            n_res = '0;
        end else if (r_neg[DIV_STAGES]) begin
            if (r_acc[DIV_STAGES] > Q_MAX_NEG) begin
                n_res = RES_MIN;
            end else begin
                n_res = -$signed(r_acc[DIV_STAGES][OUT_W-1:0]);
            end
        end else begin
            if (r_acc[DIV_STAGES] > Q_MAX_POS) begin
                n_res = RES_MAX;
            end else begin
                n_res = $signed(r_acc[DIV_STAGES][OUT_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[DIV_STAGES-1:0], i_ctl.vld};
            r_out_vld <= r_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc[0] <= ACC_W'(w_nabs[QW-1:0]);
        r_rem[0] <= '0;
        r_dm[0]  <= w_dabs[DM_W-1:0];
        r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        r_bad[0] <= i_ctl.bad;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_acc[s+1] <= n_acc[s];
            r_rem[s+1] <= n_rem[s];
            r_dm[s+1]  <= r_dm[s];
            r_neg[s+1] <= r_neg[s];
            r_bad[s+1] <= r_bad[s];
        end
        r_res     <= n_res;
        r_out_bad <= r_bad[DIV_STAGES];
    end

    assign o_res     = r_res;
    assign o_ctl.vld = r_out_vld;
    assign o_ctl.bad = r_out_bad;

endmodule

FILE: tb/two_point_sensor_calibration_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// two_point_sensor_calibration_tb: self-checking bench for the calibration
// Loads several calibration settings through the configuration channel and
// sends raw temperature and humidity counts. Each accepted item is scaled by a
// mirror of the calibration math, and every result strobe is compared field
// by field against the oldest reading still owed by the pipeline.
// ============================================================================
module two_point_sensor_calibration_tb;
    import tpsc_pkg::*;

    // One expected result item: both scaled channels and their span flags.
    typedef struct {
        t_out temp;
        t_out humid;
        logic temp_bad;
        logic humid_bad;
    } t_calib_reading;

    localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam t_raw   RAW_MIN = 16'sh8000;
    localparam t_raw   RAW_MAX = 16'sh7fff;

    // Mirrors the calibration registers, predicts each reading and checks
    // the strobed results in order.
    class calib_scoreboard;
        longint         raw_lo  [N_CH];
        longint         raw_hi  [N_CH];
        longint         cal_lo  [N_CH];
        longint         cal_hi  [N_CH];
        t_calib_reading expected_readings[$];
        int             mismatch_count;
        int             unexpected_count;

        function new();
            mismatch_count   = 0;
            unexpected_count = 0;
            for (int ch = 0; ch < N_CH; ch++) begin
                raw_lo[ch] = 0;
                raw_hi[ch] = 1;
                cal_lo[ch] = 0;
                cal_hi[ch] = 0;
            end
        endfunction

        // Only the low bits as wide as the register survive a write.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TEMP_X0:  raw_lo[CH_TEMP]  = longint'($signed(data[X_W-1:0]));
                CFG_TEMP_X1:  raw_hi[CH_TEMP]  = longint'($signed(data[X_W-1:0]));
                CFG_TEMP_Y0:  cal_lo[CH_TEMP]  = longint'(data[Y_W-1:0]);
                CFG_TEMP_Y1:  cal_hi[CH_TEMP]  = longint'(data[Y_W-1:0]);
                CFG_HUMID_X0: raw_lo[CH_HUMID] = longint'($signed(data[X_W-1:0]));
                CFG_HUMID_X1: raw_hi[CH_HUMID] = longint'($signed(data[X_W-1:0]));
                CFG_HUMID_Y0: cal_lo[CH_HUMID] = longint'(data[HUMID_Y_W-1:0]);
                CFG_HUMID_Y1: cal_hi[CH_HUMID] = longint'(data[HUMID_Y_W-1:0]);
                default: ;
            endcase
        endfunction

        // Interpolated, scaled value of one channel; all terms fit in 64 bits.
        function void calibrated_value(int ch, t_raw x, output t_out y, output logic bad);
            longint span;
            longint num;
            longint quot;
            longint scale;
            longint div_k;
            span  = raw_hi[ch] - raw_lo[ch];
            scale = (ch == CH_TEMP) ? TEMP_SCALE : HUMID_SCALE;
            div_k = (ch == CH_TEMP) ? TEMP_DIV_K : HUMID_DIV_K;
            if (span == 0) begin
                bad = 1'b1;
                y   = '0;
                return;
            end
            bad  = 1'b0;
            num  = (cal_lo[ch] * span
                    + (cal_hi[ch] - cal_lo[ch]) * (longint'(x) - raw_lo[ch])) * scale;
            quot = num / (span * div_k);
            if (quot > OUT_MAX) quot = OUT_MAX;
            if (quot < OUT_MIN) quot = OUT_MIN;
            y = t_out'(quot);
        endfunction

        function void note_item(t_raw temp_raw, t_raw humid_raw);
            t_calib_reading r;
            calibrated_value(CH_TEMP, temp_raw, r.temp, r.temp_bad);
            calibrated_value(CH_HUMID, humid_raw, r.humid, r.humid_bad);
            expected_readings.push_back(r);
        endfunction

        function void check_result(t_out temp, t_out humid, logic temp_bad, logic humid_bad);
            t_calib_reading r;
            if (expected_readings.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result: temp=%0d humid=%0d flags=%b%b",
                             temp, humid, temp_bad, humid_bad);
                return;
            end
            r = expected_readings.pop_front();
            if (temp !== r.temp || humid !== r.humid ||
                temp_bad !== r.temp_bad || humid_bad !== r.humid_bad) begin
                mismatch_count++;
                if (mismatch_count + unexpected_count <= 10) begin
                    $display("mismatch: expected temp=%0d humid=%0d flags=%b%b",
                             r.temp, r.humid, r.temp_bad, r.humid_bad);
                    $display("          got      temp=%0d humid=%0d flags=%b%b",
                             temp, humid, temp_bad, humid_bad);
                end
            end
        endfunction

        function int failures();
            return mismatch_count + unexpected_count + expected_readings.size();
        endfunction
    endclass

    // Every input starts at a known value; reset is held low from time zero.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic                    o_busy;
    t_raw                    i_raw_temperature = '0;
    t_raw                    i_raw_humidity = '0;
    logic                    o_valid;
    t_out                    o_temperature_scaled;
    t_out                    o_humidity_scaled;
    logic                    o_temp_span_invalid;
    logic                    o_humid_span_invalid;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    calib_scoreboard sb;
    int              idle_pct = 0;  // chance in percent that the sender skips a cycle

    two_point_sensor_calibration i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_raw_temperature    (i_raw_temperature),
        .i_raw_humidity       (i_raw_humidity),
        .o_valid              (o_valid),
        .o_temperature_scaled (o_temperature_scaled),
        .o_humidity_scaled    (o_humidity_scaled),
        .o_temp_span_invalid  (o_temp_span_invalid),
        .o_humid_span_invalid (o_humid_span_invalid),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Results are sampled right at the rising edge, so the values seen are the
    // ones held during the cycle that the edge closes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_temperature_scaled, o_humidity_scaled,
                            o_temp_span_invalid, o_humid_span_invalid);
    end

    // One item: optional idle cycles first, then start is held until an edge
    // finds busy low. Start is left high so back-to-back items need no toggle.
    task automatic send_item(input t_raw temp_raw, input t_raw humid_raw);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_raw_temperature <= temp_raw;
        i_raw_humidity    <= humid_raw;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(temp_raw, humid_raw);
    endtask

    // Valid stays high across a burst of writes; the caller lowers it.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Loads both calibration pairs, then pokes an index past the last
    // register, which the block must ignore.
    task automatic load_calibration(input t_raw tx0, input t_raw tx1,
                                    input logic [CFG_DATA_W-1:0] ty0,
                                    input logic [CFG_DATA_W-1:0] ty1,
                                    input t_raw hx0, input t_raw hx1,
                                    input logic [CFG_DATA_W-1:0] hy0,
                                    input logic [CFG_DATA_W-1:0] hy1);
        write_cfg(CFG_TEMP_X0, tx0);
        write_cfg(CFG_TEMP_X1, tx1);
        write_cfg(CFG_TEMP_Y0, ty0);
        write_cfg(CFG_TEMP_Y1, ty1);
        write_cfg(CFG_HUMID_X0, hx0);
        write_cfg(CFG_HUMID_X1, hx1);
        write_cfg(CFG_HUMID_Y0, hy0);
        write_cfg(CFG_HUMID_Y1, hy1);
        write_cfg(CFG_IDX_W'($urandom_range(CFG_HUMID_Y1 + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Lets the pipeline empty out; configuration is only touched when idle.
    task automatic wait_drained();
        i_start <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // Second calibration point: mostly anywhere, sometimes on top of the first
    // point (zero span) or right next to it.
    function automatic t_raw pick_span_end(t_raw x0);
        case ($urandom_range(0, 5))
            0:       return x0;
            1:       return x0 + t_raw'($urandom_range(1, 4));
            2:       return x0 - t_raw'($urandom_range(1, 4));
            default: return t_raw'($urandom);
        endcase
    endfunction

    // Raw counts: mostly uniform, some clustered around the cal points, some at the range ends.
    function automatic t_raw pick_raw(t_raw x0, t_raw x1);
        case ($urandom_range(0, 9))
            0:       return x0 + t_raw'($urandom_range(0, 8)) - t_raw'(4);
            1:       return x1 + t_raw'($urandom_range(0, 8)) - t_raw'(4);
            2:       return $urandom_range(0, 1) ? RAW_MIN : RAW_MAX;
            default: return t_raw'($urandom);
        endcase
    endfunction

    initial begin
        int   idle_plan [5];
        t_raw tx0, tx1, hx0, hx1;

        idle_plan = '{0, 71, 30, 0, 71};
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: span of one, both calibration values zero, so
        // every reading is zero with no flags.
        idle_pct = 0;
        send_item(RAW_MIN, RAW_MAX);
        send_item(RAW_MAX, RAW_MIN);
        wait_drained();

        // Full-scale spans, temperature rising and humidity falling. The
        // calibration values carry junk in the bits above the register width.
        load_calibration(RAW_MIN, RAW_MAX, 16'hfc00, 16'hffff,
                         RAW_MAX, RAW_MIN, 16'h00ff, 16'hff00);
        send_item(RAW_MIN, RAW_MIN);
        send_item(RAW_MAX, RAW_MAX);
        send_item('0, '0);
        send_item(-16'sd1, -16'sd1);
        send_item(16'sd12345, -16'sd12345);
        wait_drained();

        // Spans of one count at the ends of the range, so the raw offset is
        // extrapolated across the whole range for the largest magnitudes.
        load_calibration(RAW_MAX - 16'sd1, RAW_MAX, 16'd1023, 16'd0,
                         RAW_MIN, RAW_MIN + 16'sd1, 16'd0, 16'd255);
        send_item(RAW_MIN, RAW_MAX);
        send_item(RAW_MAX, RAW_MIN);
        send_item(RAW_MAX - 16'sd1, RAW_MIN);
        send_item('0, '0);
        wait_drained();

        // Zero span on both channels: flags set and results forced to zero.
        load_calibration(RAW_MIN, RAW_MIN, 16'd1023, 16'd1023,
                         RAW_MAX, RAW_MAX, 16'd255, 16'd255);
        send_item('0, '0);
        send_item(RAW_MIN, RAW_MAX);
        wait_drained();

        // Zero span on temperature only, humidity on a falling span.
        load_calibration('0, '0, 16'd512, 16'd3,
                         16'sd1000, -16'sd1000, 16'd7, 16'd200);
        send_item(RAW_MAX, 16'sd500);
        send_item(RAW_MIN, RAW_MIN);
        wait_drained();

        // Random phases, each with a fresh calibration and its own idle mix.
        for (int phase = 0; phase < 5; phase++) begin
            tx0 = t_raw'($urandom);
            tx1 = pick_span_end(tx0);
            hx0 = t_raw'($urandom);
            hx1 = pick_span_end(hx0);
            load_calibration(tx0, tx1, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             hx0, hx1, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            idle_pct = idle_plan[phase];
            for (int n = 0; n < 127; n++) begin
                // Once in the run the sender holds off until every reading
                // owed so far has come out.
                if (phase == 1 && n == 60)
                    wait_drained();
                send_item(pick_raw(tx0, tx1), pick_raw(hx0, hx1));
            end
            wait_drained();
        end

        // Any stray strobe after the last reading is caught by the monitor.
        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.failures() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
